[src/gbgi_pkg.sv]
// Package for the guarded bilinear grid interpolator.
// Holds shared defaults, command codes and the cell and control types.
// No dependencies.
package gbgi_pkg;

  localparam int GRID_WIDTH_DEF  = 64;
  localparam int GRID_HEIGHT_DEF = 64;
  localparam int FRAC_BITS_DEF   = 8;

  localparam logic        CMD_WRITE      = 1'b0;
  localparam logic        CMD_QUERY      = 1'b1;
  localparam logic [15:0] DEPTH_DIFF_RST = 16'hFFFF;

  localparam int CELL_W = 65;

  // One stored grid cell
  typedef struct packed {
    logic               valid;
    logic signed [15:0] depth;
    logic signed [15:0] vz;
    logic signed [15:0] vy;
    logic signed [15:0] vx;
  } cell_t;

  // Per-item control carried down the pipeline
  typedef struct packed {
    logic       is_wr;    // write transaction, no result
    logic       wr_en;    // write lands inside the grid
    logic [1:0] wr_bank;  // {row parity, column parity}
    logic       in_range; // query position inside the grid
    logic       ix0;      // column parity of the base corner
    logic       iy0;      // row parity of the base corner
  } ctl_t;

endpackage

[src/gbgi_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Used for the four grid banks. No dependencies.
module gbgi_ram #(
  parameter  int WIDTH = 8,
  parameter  int DEPTH = 16,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port, held while re_i is low
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[src/gbgi_decode.sv]
// Stage 1 of the interpolator: decodes a write or query transaction into
// bank addresses, corner weights and control. Depends on gbgi_pkg.
module gbgi_decode import gbgi_pkg::*; #(
  parameter  int GRID_WIDTH  = GRID_WIDTH_DEF,
  parameter  int GRID_HEIGHT = GRID_HEIGHT_DEF,
  parameter  int FRAC_BITS   = FRAC_BITS_DEF,
  localparam int HW          = (GRID_WIDTH + 1) / 2,
  localparam int HH          = (GRID_HEIGHT + 1) / 2,
  localparam int BD          = HW * HH,
  localparam int AW          = (BD > 1) ? $clog2(BD) : 1,
  localparam int WW          = 2 * FRAC_BITS + 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 accept_i,
  input  logic                 cmd_i,
  input  logic [5:0]           cell_x_i,
  input  logic [5:0]           cell_y_i,
  input  cell_t                cell_i,
  input  logic signed [15:0]   query_x_i,
  input  logic signed [15:0]   query_y_i,
  output logic                 valid_o,
  output ctl_t                 ctl_o,
  output logic [AW-1:0]        wr_addr_o,
  output cell_t                wr_cell_o,
  output logic [3:0][AW-1:0]   rd_addr_o,
  output logic [3:0][WW-1:0]   w_o        // ff, fc, cf, cc
);

  localparam int LIM_X = (GRID_WIDTH - 1) << FRAC_BITS;
  localparam int LIM_Y = (GRID_HEIGHT - 1) << FRAC_BITS;
  localparam int ONE   = 1 << FRAC_BITS;

  logic                valid_q;
  ctl_t                ctl_d, ctl_q;
  logic [AW-1:0]       wr_addr_d, wr_addr_q;
  cell_t               wr_cell_q;
  logic [3:0][AW-1:0]  rd_addr_d, rd_addr_q;
  logic [3:0][WW-1:0]  w_d, w_q;

  int unsigned         wx, wy, ix, iy, cx, cy;
  logic [FRAC_BITS-1:0] fx, fy;
  logic [FRAC_BITS:0]   omx, omy;

  // write decode, then query decode: range check, corner addresses per bank, weights
  always_comb begin
    wx = 32'(cell_x_i);
    wy = 32'(cell_y_i);
    ctl_d.is_wr   = (cmd_i == CMD_WRITE);
    ctl_d.wr_en   = (cmd_i == CMD_WRITE) && (wx < GRID_WIDTH) && (wy < GRID_HEIGHT);
    ctl_d.wr_bank = {cell_y_i[0], cell_x_i[0]};
    wr_addr_d     = AW'((wy >> 1) * HW + (wx >> 1));

    ctl_d.in_range = (query_x_i >= 16'sd0) && (query_y_i >= 16'sd0) &&
                     (32'(query_x_i) < LIM_X) && (32'(query_y_i) < LIM_Y);
    ix = 32'($unsigned(query_x_i)) >> FRAC_BITS;
    iy = 32'($unsigned(query_y_i)) >> FRAC_BITS;
    ctl_d.ix0 = ix[0];
    ctl_d.iy0 = iy[0];
    for (int b = 0; b < 4; b++) begin
      cx = ix + 32'(ix[0] ^ b[0]);
      cy = iy + 32'(iy[0] ^ b[1]);
      rd_addr_d[b] = AW'((cy >> 1) * HW + (cx >> 1));
    end
    fx  = query_x_i[FRAC_BITS-1:0];
    fy  = query_y_i[FRAC_BITS-1:0];
    omx = (FRAC_BITS+1)'(ONE) - {1'b0, fx};
    omy = (FRAC_BITS+1)'(ONE) - {1'b0, fy};
    w_d[0] = WW'(omx) * WW'(omy);
    w_d[1] = WW'(omx) * WW'(fy);
    w_d[2] = WW'(fx) * WW'(omy);
    w_d[3] = WW'(fx) * WW'(fy);
  end

  // stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= accept_i;
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ctl_q     <= ctl_d;
      wr_addr_q <= wr_addr_d;
      wr_cell_q <= cell_i;
      rd_addr_q <= rd_addr_d;
      w_q       <= w_d;
    end
  end

  assign valid_o   = valid_q;
  assign ctl_o     = ctl_q;
  assign wr_addr_o = wr_addr_q;
  assign wr_cell_o = wr_cell_q;
  assign rd_addr_o = rd_addr_q;
  assign w_o       = w_q;

endmodule

[src/gbgi_blend.sv]
// Stages 3 and 4: corner checks and weighted products, then the sum,
// rounding and the result register. Depends on gbgi_pkg.
module gbgi_blend import gbgi_pkg::*; #(
  parameter  int FRAC_BITS = FRAC_BITS_DEF,
  localparam int WW        = 2 * FRAC_BITS + 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  logic               in_range_i,
  input  cell_t [3:0]        corner_i,   // ff, fc, cf, cc
  input  logic [3:0][WW-1:0] w_i,
  input  logic [15:0]        max_diff_i,
  output logic               valid_o,
  output logic               ok_o,
  output logic [2:0][15:0]   value_o
);

  localparam int PW   = 16 + WW + 1;
  localparam int SW   = PW + 2;
  localparam int HALF = 1 << (2 * FRAC_BITS - 1);

  logic                         v3_q, ok3_d, ok3_q;
  logic signed [2:0][3:0][PW-1:0] p_d, p_q;
  logic                         v4_q, ok4_q;
  logic [2:0][15:0]             val_d, val_q;

  logic signed [15:0] comp;
  logic signed [16:0] dd;
  logic [16:0]        ad;
  logic               dep_ok;
  logic signed [SW-1:0] sum;

  // corner checks and products
  always_comb begin
    dep_ok = 1'b1;
    for (int c = 0; c < 3; c++) begin
      dd = {corner_i[3].depth[15], corner_i[3].depth} -
           {corner_i[c].depth[15], corner_i[c].depth};
      ad = dd[16] ? 17'(-dd) : 17'(dd);
      if (ad[15:0] > max_diff_i) begin
        dep_ok = 1'b0;
      end
    end
    ok3_d = in_range_i && dep_ok && corner_i[0].valid && corner_i[1].valid &&
            corner_i[2].valid && corner_i[3].valid;
    for (int c = 0; c < 4; c++) begin
      for (int k = 0; k < 3; k++) begin
        comp = (k == 0) ? corner_i[c].vx : ((k == 1) ? corner_i[c].vy : corner_i[c].vz);
        p_d[k][c] = PW'(comp) * $signed({1'b0, w_i[c]});
      end
    end
  end

  // sum of four signed products, round to nearest (ties up), zero when rejected
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sum = SW'($signed(p_q[k][0])) + SW'($signed(p_q[k][1])) +
            SW'($signed(p_q[k][2])) + SW'($signed(p_q[k][3])) + SW'(HALF);
      sum = sum >>> (2 * FRAC_BITS);
      val_d[k] = ok3_q ? sum[15:0] : 16'd0;
    end
  end

  // stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en_i) begin
      v3_q <= valid_i;
      v4_q <= v3_q;
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ok3_q <= ok3_d;
      p_q   <= p_d;
      ok4_q <= ok3_q;
      val_q <= val_d;
    end
  end

  assign valid_o = v4_q;
  assign ok_o    = ok4_q;
  assign value_o = val_q;

endmodule

[src/guarded_bilinear_grid_interp_top.sv]
// Top level of the guarded bilinear grid interpolator.
// Depends on gbgi_pkg, gbgi_ram, gbgi_decode and gbgi_blend.
//
//   channel  | direction | contents
//   s_axis   | in        | cell write or query transaction, cmd in tuser
//   m_axis   | out       | one result per query, ok flag in tuser
//   cfg      | in        | max_depth_diff register write
//
// One transaction per cycle in while m_axis does not stall; each query result
// passes decode, bank read, checks and products, then sum and round in order.
// The grid is four RAM banks split by row and column parity, so the four
// corners of a query are read in the same cycle, one from each bank.
// After reset a clearing pass over all ceil(W/2)*ceil(H/2) addresses (1024 by
// default) zeroes every cell; s_axis_tready stays low until it ends.
// A stall on m_axis freezes the whole pipeline; nothing is lost or repeated.
module guarded_bilinear_grid_interp_top import gbgi_pkg::*; #(
  parameter  int GRID_WIDTH  = GRID_WIDTH_DEF,
  parameter  int GRID_HEIGHT = GRID_HEIGHT_DEF,
  parameter  int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // cell_x[5:0] cell_y[11:6] cell_vx[27:12] cell_vy[43:28] cell_vz[59:44]
  // cell_depth[75:60] cell_valid[76] query_x[92:77] query_y[108:93] zero[111:109]
  input  logic [111:0] s_axis_tdata,
  // cmd[0]
  input  logic         s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // value_x[15:0] value_y[31:16] value_z[47:32]
  output logic [47:0]  m_axis_tdata,
  // ok[0]
  output logic         m_axis_tuser,
  input  logic         cfg_we_i,
  input  logic [15:0]  cfg_wdata_i
);

  localparam int HW = (GRID_WIDTH + 1) / 2;
  localparam int HH = (GRID_HEIGHT + 1) / 2;
  localparam int BD = HW * HH;
  localparam int AW = (BD > 1) ? $clog2(BD) : 1;
  localparam int WW = 2 * FRAC_BITS + 1;

  logic               en, accept;
  logic [15:0]        max_diff_q;
  logic               clr_busy_q;
  logic [AW-1:0]      clr_cnt_q;

  cell_t              in_cell;
  logic               v1;
  ctl_t               ctl1;
  logic [AW-1:0]      wr_addr1;
  cell_t              wr_cell1;
  logic [3:0][AW-1:0] rd_addr1;
  logic [3:0][WW-1:0] w1;

  logic               v2_q, in_range2_q, ix0_q, iy0_q;
  logic [3:0][WW-1:0] w2_q;
  cell_t [3:0]        bank_rd;
  cell_t [3:0]        corner;

  logic               ok4;
  logic [2:0][15:0]   value4;

  // global advance: the output register is free or being taken
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en && !clr_busy_q;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // depth limit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_diff_q <= DEPTH_DIFF_RST;
    end else if (cfg_we_i) begin
      max_diff_q <= cfg_wdata_i;
    end
  end

  // clearing pass after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_cnt_q  <= '0;
    end else if (clr_busy_q) begin
      clr_cnt_q <= clr_cnt_q + AW'(1);
      if (clr_cnt_q == AW'(BD - 1)) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  assign in_cell.vx    = s_axis_tdata[27:12];
  assign in_cell.vy    = s_axis_tdata[43:28];
  assign in_cell.vz    = s_axis_tdata[59:44];
  assign in_cell.depth = s_axis_tdata[75:60];
  assign in_cell.valid = s_axis_tdata[76];

  // stage 1: decode
  gbgi_decode #(
    .GRID_WIDTH (GRID_WIDTH),
    .GRID_HEIGHT(GRID_HEIGHT),
    .FRAC_BITS  (FRAC_BITS)
  ) u_decode (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .accept_i (accept),
    .cmd_i    (s_axis_tuser),
    .cell_x_i (s_axis_tdata[5:0]),
    .cell_y_i (s_axis_tdata[11:6]),
    .cell_i   (in_cell),
    .query_x_i(s_axis_tdata[92:77]),
    .query_y_i(s_axis_tdata[108:93]),
    .valid_o  (v1),
    .ctl_o    (ctl1),
    .wr_addr_o(wr_addr1),
    .wr_cell_o(wr_cell1),
    .rd_addr_o(rd_addr1),
    .w_o      (w1)
  );

  // stage 2: grid banks, indexed {row parity, column parity}
  for (genvar b = 0; b < 4; b++) begin : g_bank
    logic          we;
    logic [AW-1:0] waddr;
    cell_t         wdata;

    always_comb begin
      if (clr_busy_q) begin
        we    = 1'b1;
        waddr = clr_cnt_q;
        wdata = '0;
      end else begin
        we    = en && v1 && ctl1.wr_en && (ctl1.wr_bank == 2'(b));
        waddr = wr_addr1;
        wdata = wr_cell1;
      end
    end

    gbgi_ram #(
      .WIDTH(CELL_W),
      .DEPTH(BD)
    ) u_ram (
      .clk_i  (clk_i),
      .we_i   (we),
      .waddr_i(waddr),
      .wdata_i(wdata),
      .re_i   (en),
      .raddr_i(rd_addr1[b]),
      .rdata_o(bank_rd[b])
    );
  end

  // stage 2 valid, queries only
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en) begin
      v2_q <= v1 && !ctl1.is_wr;
    end
  end

  // stage 2 payload alongside the bank reads
  always_ff @(posedge clk_i) begin
    if (en) begin
      in_range2_q <= ctl1.in_range;
      ix0_q       <= ctl1.ix0;
      iy0_q       <= ctl1.iy0;
      w2_q        <= w1;
    end
  end

  // banks back to corners: ff, fc, cf, cc
  assign corner[0] = bank_rd[{iy0_q,  ix0_q}];
  assign corner[1] = bank_rd[{!iy0_q, ix0_q}];
  assign corner[2] = bank_rd[{iy0_q,  !ix0_q}];
  assign corner[3] = bank_rd[{!iy0_q, !ix0_q}];

  // stages 3 and 4
  gbgi_blend #(
    .FRAC_BITS(FRAC_BITS)
  ) u_blend (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .valid_i   (v2_q),
    .in_range_i(in_range2_q),
    .corner_i  (corner),
    .w_i       (w2_q),
    .max_diff_i(max_diff_q),
    .valid_o   (m_axis_tvalid),
    .ok_o      (ok4),
    .value_o   (value4)
  );

  assign m_axis_tuser = ok4;
  assign m_axis_tdata = value4;

endmodule
